// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/blapd_pkg.sv =====
// ----------------------------------------------------------------------------
// blapd_pkg
// types and constants of the bounded list with append, pop and delete
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blapd_pkg;

  localparam int unsigned DepthDef      = 64;
  localparam int unsigned ValueWidthDef = 32;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DELETE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_NO_MATCH = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DEL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         length;
    logic signed [31:0] popped_value;
    logic [6:0]         removed_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/blapd_ram.sv =====
// ----------------------------------------------------------------------------
// blapd_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blapd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/bounded_list_append_pop_delete.sv =====
// ----------------------------------------------------------------------------
// bounded_list_append_pop_delete
// ordered list of signed words with append, pop tail and delete by value
// ----------------------------------------------------------------------------
// The list lives in one ram of DEPTH words with a registered read; reset
// clears only the entry count, state and output valid, so no entry is
// cleared after reset and the block takes a word at once. One request is in
// work at a time and each gives exactly one result word. Append goes from
// acceptance straight to the result, pop first reads the tail entry from the
// ram, and delete walks the list: it reads one entry per cycle and writes
// each kept entry back at the compaction pointer, which always trails the
// read pointer so the two ram ports never touch the same entry. The result
// waits in an output register; the next request is taken once it is loaded.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bounded_list_append_pop_delete #(
  parameter int unsigned DEPTH       = blapd_pkg::DepthDef,
  parameter int unsigned VALUE_WIDTH = blapd_pkg::ValueWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // request channel
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire blapd_pkg::req_t in_i,
  // result channel
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output blapd_pkg::rsp_t      out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // control state
  blapd_pkg::state_e state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q, out_valid_d;

  // request and walk registers
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]          chk_q, chk_d;   // index of the entry now on rdata
  logic [CW-1:0]          wr_q, wr_d;     // compaction write pointer
  logic [CW-1:0]          rem_q, rem_d;   // matches removed so far
  blapd_pkg::rsp_t        res_q, res_d;   // result being built
  blapd_pkg::rsp_t        out_q, out_d;

  // ram port
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic                   in_acc;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] in_val;
  logic                   del_match;
  logic                   del_last;
  logic [CW-1:0]          chk_nxt;

  blapd_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != blapd_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // the input is sign-extended or cut to the stored width
  assign in_val    = VALUE_WIDTH'(in_i.value);
  assign del_match = (ram_rdata == val_q);
  assign chk_nxt   = chk_q + CW'(1);
  assign del_last  = (chk_nxt == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      blapd_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = blapd_pkg::S_DONE;
          if (count_q != '0) begin
            case (in_i.mode)
              blapd_pkg::MODE_POP:    state_d = blapd_pkg::S_POP;
              blapd_pkg::MODE_DELETE: state_d = blapd_pkg::S_DEL;
              default:                state_d = blapd_pkg::S_DONE;
            endcase
          end
        end
      end
      blapd_pkg::S_POP: state_d = blapd_pkg::S_DONE;
      blapd_pkg::S_DEL: begin
        if (del_last) begin
          state_d = blapd_pkg::S_DONE;
        end
      end
      blapd_pkg::S_DONE: begin
        if (out_free) begin
          state_d = blapd_pkg::S_IDLE;
        end
      end
      default: state_d = blapd_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    count_d     = count_q;
    val_d       = val_q;
    chk_d       = chk_q;
    wr_d        = wr_q;
    rem_d       = rem_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_wdata   = in_val;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      blapd_pkg::S_IDLE: begin
        if (in_acc) begin
          val_d        = in_val;
          chk_d        = '0;
          wr_d         = '0;
          rem_d        = '0;
          res_d        = '0;
          res_d.length = 7'(count_q);
          case (in_i.mode)
            blapd_pkg::MODE_APPEND: begin
              if (count_q == CW'(DEPTH)) begin
                res_d.status = blapd_pkg::STATUS_FULL;
              end else begin
                ram_we       = 1'b1;
                count_d      = count_q + CW'(1);
                res_d.length = 7'(count_q + CW'(1));
              end
            end
            blapd_pkg::MODE_POP: begin
              if (count_q == '0) begin
                res_d.status = blapd_pkg::STATUS_EMPTY;
              end else begin
                ram_re              = 1'b1;
                ram_raddr           = AW'(count_q - CW'(1));
                count_d             = count_q - CW'(1);
                res_d.length        = 7'(count_q - CW'(1));
                res_d.removed_count = 7'd1;
              end
            end
            blapd_pkg::MODE_DELETE: begin
              if (count_q == '0) begin
                res_d.status = blapd_pkg::STATUS_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
              end
            end
            default: ;  // unused code leaves the list alone
          endcase
        end
      end
      blapd_pkg::S_POP: begin
        // popped entry shown zero-extended or cut to the field width
        res_d.popped_value = 32'(ram_rdata);
      end
      blapd_pkg::S_DEL: begin
        if (del_match) begin
          rem_d = rem_q + CW'(1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = wr_q[AW-1:0];
          ram_wdata = ram_rdata;
          wr_d      = wr_q + CW'(1);
        end
        if (!del_last) begin
          // read ahead while the write pointer trails
          ram_re    = 1'b1;
          ram_raddr = chk_nxt[AW-1:0];
          chk_d     = chk_nxt;
        end else begin
          count_d             = del_match ? wr_q : wr_q + CW'(1);
          res_d.length        = del_match ? 7'(wr_q) : 7'(wr_q + CW'(1));
          res_d.removed_count = del_match ? 7'(rem_q + CW'(1)) : 7'(rem_q);
          res_d.status        = (!del_match && rem_q == '0) ?
                                blapd_pkg::STATUS_NO_MATCH : blapd_pkg::STATUS_OK;
        end
      end
      blapd_pkg::S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blapd_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    chk_q <= chk_d;
    wr_q  <= wr_d;
    rem_q <= rem_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // list never grows past its depth
  `ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(DEPTH))
  // every entry walked so far was either kept or removed
  `ASSERT_IMPLIES(a_del_balance, clk_i, rst_ni, state_q == blapd_pkg::S_DEL,
                  (wr_q + rem_q) == chk_q)
  // the walk stays inside the list
  `ASSERT_IMPLIES(a_del_inside, clk_i, rst_ni, state_q == blapd_pkg::S_DEL, chk_q < count_q)
  // an accepted request always leaves idle
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_acc, state_q != blapd_pkg::S_IDLE)

endmodule

`default_nettype wire
